### hw/rtl/drsq_pkg.sv
`default_nettype none

package drsq_pkg;

   // Default depth of each job store
   localparam int QUEUE_DEPTH_DEF = 8;

   // Configuration port geometry
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_RETRY_LIMIT   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RETRY_DELAY   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KINDS_ENABLED = 2'd2;

   // Configuration reset values
   localparam logic [2:0]  RETRY_LIMIT_RST   = 3'd3;
   localparam logic [15:0] RETRY_DELAY_RST   = 16'd5000;
   localparam logic [3:0]  KINDS_ENABLED_RST = 4'hF;

   // The settings reply never gets a retry budget
   localparam logic [1:0] KIND_SETTINGS = 2'd1;

   typedef enum logic [1:0] {
      MODE_ENQ  = 2'd0,
      MODE_ACK  = 2'd1,
      MODE_NACK = 2'd2,
      MODE_TICK = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_RETRY,
      ST_TRY,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [2:0]  retry_limit;
      logic [15:0] retry_delay_ticks;
      logic [3:0]  kinds_enabled;
   } cfg_type;

   // Controller to datapath
   typedef struct packed {
      logic capture;
      logic enq_push;
      logic release_flight;
      logic hold_flight;
      logic timer_dec;
      logic timer_cancel;
      logic move_held;
      logic flush;
      logic arm_timer;
      logic send_head;
      logic hold_head;
      logic load_result;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      mode_type mode;
      logic     kind_listed;
      logic     in_flight;
      logic     timer_running;
      logic     timer_expire;
      logic     held_nonempty;
      logic     work_empty;
      logic     work_full;
      logic     link_up;
      logic     head_ok;
      logic     rsp_free;
   } status_type;

endpackage

`default_nettype wire

### hw/rtl/drsq_if.sv
`default_nettype none

// Request channel: one scheduler event
interface drsq_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] mode;
   logic [1:0] job_kind;
   logic       link_up;
   logic       outbox_accepts;

   modport source (output valid, mode, job_kind, link_up, outbox_accepts, input ready);
   modport sink   (input valid, mode, job_kind, link_up, outbox_accepts, output ready);
endinterface

// Response channel: scheduler status after one event
interface drsq_rsp_if;
   logic       valid;
   logic       ready;
   logic       send_valid;
   logic [1:0] send_kind;
   logic       busy_res;
   logic [3:0] queue_count;
   logic [3:0] failed_count;
   logic       timer_armed;
   logic [3:0] pending_mask;

   modport source (output valid, send_valid, send_kind, busy_res, queue_count,
                   failed_count, timer_armed, pending_mask, input ready);
   modport sink   (input valid, send_valid, send_kind, busy_res, queue_count,
                   failed_count, timer_armed, pending_mask, output ready);
endinterface

`default_nettype wire

### hw/rtl/drsq_ctrl.sv
`default_nettype none

module drsq_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire drsq_pkg::status_type status,
   output drsq_pkg::cmd_type        cmd
);

   drsq_pkg::state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= drsq_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         drsq_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = drsq_pkg::ST_DECODE;
            end
         end
         drsq_pkg::ST_DECODE: begin
            state_in = drsq_pkg::ST_FINISH;
            case (status.mode)
               drsq_pkg::MODE_ENQ: begin
                  if (!status.kind_listed) begin
                     cmd.enq_push = 1'b1;
                     state_in     = drsq_pkg::ST_TRY;
                  end
               end
               drsq_pkg::MODE_ACK: begin
                  if (status.in_flight) begin
                     cmd.release_flight = 1'b1;
                     state_in           = drsq_pkg::ST_TRY;
                  end
               end
               drsq_pkg::MODE_NACK: begin
                  if (status.in_flight) begin
                     cmd.release_flight = 1'b1;
                     cmd.hold_flight    = 1'b1;
                     state_in           = drsq_pkg::ST_TRY;
                  end
               end
               drsq_pkg::MODE_TICK: begin
                  if (status.timer_running) begin
                     if (status.timer_expire) begin
                        cmd.timer_cancel = 1'b1;
                        state_in         = drsq_pkg::ST_RETRY;
                     end else begin
                        cmd.timer_dec = 1'b1;
                     end
                  end
               end
               default: begin
                  state_in = drsq_pkg::ST_FINISH;
               end
            endcase
         end
         // Retry pass: one failed job back into the work queue per cycle
         drsq_pkg::ST_RETRY: begin
            if (status.held_nonempty && !status.work_full) begin
               cmd.move_held = 1'b1;
            end else begin
               state_in = drsq_pkg::ST_TRY;
            end
         end
         // Send attempt: refused heads are popped one per cycle and held only while they have retry budget left
         drsq_pkg::ST_TRY: begin
            if (status.in_flight) begin
               state_in = drsq_pkg::ST_FINISH;
            end else if (!status.link_up) begin
               cmd.flush = 1'b1;
               state_in  = drsq_pkg::ST_FINISH;
            end else if (status.work_empty) begin
               cmd.arm_timer = status.held_nonempty && !status.timer_running;
               state_in      = drsq_pkg::ST_FINISH;
            end else if (status.head_ok) begin
               cmd.send_head = 1'b1;
               state_in      = drsq_pkg::ST_FINISH;
            end else begin
               cmd.hold_head = 1'b1;
            end
         end
         drsq_pkg::ST_FINISH: begin
            if (status.rsp_free) begin
               cmd.load_result = 1'b1;
               state_in        = drsq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = drsq_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

### hw/rtl/drsq_datapath.sv
`default_nettype none

module drsq_datapath #(
   parameter int QUEUE_DEPTH = drsq_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire drsq_pkg::cfg_type    cfg,
   input  wire drsq_pkg::cmd_type    cmd,
   output drsq_pkg::status_type      status,
   input  wire logic [1:0]           req_mode,
   input  wire logic [1:0]           req_job_kind,
   input  wire logic                 req_link_up,
   input  wire logic                 req_outbox_accepts,
   input  wire logic                 rsp_ready,
   output logic                      rsp_valid,
   output logic                      rsp_send_valid,
   output logic [1:0]                rsp_send_kind,
   output logic                      rsp_busy_res,
   output logic [3:0]                rsp_queue_count,
   output logic [3:0]                rsp_failed_count,
   output logic                      rsp_timer_armed,
   output logic [3:0]                rsp_pending_mask
);

   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam int LEN_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(QUEUE_DEPTH);

   // Captured request
   logic [1:0] item_mode_ff;
   logic [1:0] item_kind_ff;
   logic       item_link_ff;
   logic       item_accepts_ff;

   // Work queue and failed set
   logic [1:0]       work_kind_ff [QUEUE_DEPTH];
   logic [1:0]       work_kind_in [QUEUE_DEPTH];
   logic [2:0]       work_retry_ff [QUEUE_DEPTH];
   logic [2:0]       work_retry_in [QUEUE_DEPTH];
   logic [LEN_W-1:0] work_len_ff, work_len_in;
   logic [1:0]       held_kind_ff [QUEUE_DEPTH];
   logic [1:0]       held_kind_in [QUEUE_DEPTH];
   logic [2:0]       held_retry_ff [QUEUE_DEPTH];
   logic [2:0]       held_retry_in [QUEUE_DEPTH];
   logic [LEN_W-1:0] held_len_ff, held_len_in;

   // In-flight job, retry timer, send flag
   logic        in_flight_ff, in_flight_in;
   logic [1:0]  flight_kind_ff, flight_kind_in;
   logic [2:0]  flight_retry_ff, flight_retry_in;
   logic        timer_run_ff, timer_run_in;
   logic [15:0] timer_left_ff, timer_left_in;
   logic        sent_ff, sent_in;
   logic [1:0]  sent_kind_ff, sent_kind_in;

   // Result register
   logic       rsp_valid_ff, rsp_valid_in;
   logic       res_sent_ff;
   logic [1:0] res_kind_ff;
   logic       res_busy_ff;
   logic [3:0] res_qcount_ff;
   logic [3:0] res_fcount_ff;
   logic       res_timer_ff;
   logic [3:0] res_mask_ff;

   logic             work_full, held_full;
   logic             work_pop, work_push, held_pop, held_push;
   logic [1:0]       push_kind, hold_kind;
   logic [2:0]       push_retry, hold_retry;
   logic [3:0]       pending;
   logic             rsp_free;

   assign work_full = (work_len_ff == LEN_MAX);
   assign held_full = (held_len_ff == LEN_MAX);

   // Kinds present anywhere in the scheduler
   always_comb begin
      pending = '0;
      if (in_flight_ff) begin
         pending[flight_kind_ff] = 1'b1;
      end
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         if (LEN_W'(i) < work_len_ff) begin
            pending[work_kind_ff[i]] = 1'b1;
         end
         if (LEN_W'(i) < held_len_ff) begin
            pending[held_kind_ff[i]] = 1'b1;
         end
      end
   end

   // Work queue sources: new request or failed set head
   assign work_pop   = cmd.send_head | cmd.hold_head;
   assign work_push  = cmd.enq_push | cmd.move_held;
   assign push_kind  = cmd.move_held ? held_kind_ff[0] : item_kind_ff;
   assign push_retry = cmd.move_held ? held_retry_ff[0] :
                       ((item_kind_ff == drsq_pkg::KIND_SETTINGS) ? 3'd0 : cfg.retry_limit);

   // Failed set sources: nacked job or refused head; only with budget left
   assign hold_kind  = cmd.hold_flight ? flight_kind_ff : work_kind_ff[0];
   assign hold_retry = cmd.hold_flight ? flight_retry_ff : work_retry_ff[0];
   assign held_pop   = cmd.move_held;
   assign held_push  = (cmd.hold_flight | cmd.hold_head) &&
                       (hold_kind != drsq_pkg::KIND_SETTINGS) &&
                       (hold_retry != 3'd0) && !held_full;

   // Work queue next value
   always_comb begin
      work_kind_in  = work_kind_ff;
      work_retry_in = work_retry_ff;
      work_len_in   = work_len_ff;
      if (cmd.flush) begin
         work_len_in = '0;
      end else if (work_pop) begin
         for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
            work_kind_in[i]  = work_kind_ff[i+1];
            work_retry_in[i] = work_retry_ff[i+1];
         end
         work_len_in = work_len_ff - LEN_W'(1);
      end else if (work_push && !work_full) begin
         work_kind_in[work_len_ff[IDX_W-1:0]]  = push_kind;
         work_retry_in[work_len_ff[IDX_W-1:0]] = push_retry;
         work_len_in = work_len_ff + LEN_W'(1);
      end
   end

   // Failed set next value
   always_comb begin
      held_kind_in  = held_kind_ff;
      held_retry_in = held_retry_ff;
      held_len_in   = held_len_ff;
      if (cmd.flush) begin
         held_len_in = '0;
      end else if (held_pop) begin
         for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
            held_kind_in[i]  = held_kind_ff[i+1];
            held_retry_in[i] = held_retry_ff[i+1];
         end
         held_len_in = held_len_ff - LEN_W'(1);
      end else if (held_push) begin
         held_kind_in[held_len_ff[IDX_W-1:0]]  = hold_kind;
         held_retry_in[held_len_ff[IDX_W-1:0]] = hold_retry - 3'd1;
         held_len_in = held_len_ff + LEN_W'(1);
      end
   end

   // Flight, timer and send flag next value
   always_comb begin
      in_flight_in    = in_flight_ff;
      flight_kind_in  = flight_kind_ff;
      flight_retry_in = flight_retry_ff;
      timer_run_in    = timer_run_ff;
      timer_left_in   = timer_left_ff;
      sent_in         = sent_ff;
      sent_kind_in    = sent_kind_ff;
      if (cmd.capture) begin
         sent_in      = 1'b0;
         sent_kind_in = '0;
      end
      if (cmd.release_flight) begin
         in_flight_in = 1'b0;
      end
      if (cmd.send_head) begin
         in_flight_in    = 1'b1;
         flight_kind_in  = work_kind_ff[0];
         flight_retry_in = work_retry_ff[0];
         sent_in         = 1'b1;
         sent_kind_in    = work_kind_ff[0];
      end
      if (cmd.timer_dec && timer_left_ff != 16'd0) begin
         timer_left_in = timer_left_ff - 16'd1;
      end
      if (cmd.timer_cancel || cmd.flush) begin
         timer_run_in  = 1'b0;
         timer_left_in = '0;
      end
      if (cmd.arm_timer) begin
         timer_run_in  = 1'b1;
         timer_left_in = (cfg.retry_delay_ticks == 16'd0) ? 16'd1 : cfg.retry_delay_ticks;
      end
   end

   // Result register handshake
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_result) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         work_len_ff     <= '0;
         held_len_ff     <= '0;
         in_flight_ff    <= 1'b0;
         flight_kind_ff  <= '0;
         flight_retry_ff <= '0;
         timer_run_ff    <= 1'b0;
         timer_left_ff   <= '0;
         sent_ff         <= 1'b0;
         sent_kind_ff    <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         work_len_ff     <= work_len_in;
         held_len_ff     <= held_len_in;
         in_flight_ff    <= in_flight_in;
         flight_kind_ff  <= flight_kind_in;
         flight_retry_ff <= flight_retry_in;
         timer_run_ff    <= timer_run_in;
         timer_left_ff   <= timer_left_in;
         sent_ff         <= sent_in;
         sent_kind_ff    <= sent_kind_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      work_kind_ff  <= work_kind_in;
      work_retry_ff <= work_retry_in;
      held_kind_ff  <= held_kind_in;
      held_retry_ff <= held_retry_in;
      if (cmd.capture) begin
         item_mode_ff    <= req_mode;
         item_kind_ff    <= req_job_kind;
         item_link_ff    <= req_link_up;
         item_accepts_ff <= req_outbox_accepts;
      end
      if (cmd.load_result) begin
         res_sent_ff   <= sent_ff;
         res_kind_ff   <= sent_kind_ff;
         res_busy_ff   <= in_flight_ff;
         res_qcount_ff <= 4'(work_len_ff);
         res_fcount_ff <= 4'(held_len_ff);
         res_timer_ff  <= timer_run_ff;
         res_mask_ff   <= pending;
      end
   end

   // Status to the controller
   always_comb begin
      status.mode          = drsq_pkg::mode_type'(item_mode_ff);
      status.kind_listed   = pending[item_kind_ff];
      status.in_flight     = in_flight_ff;
      status.timer_running = timer_run_ff;
      status.timer_expire  = (timer_left_ff <= 16'd1);
      status.held_nonempty = (held_len_ff != '0);
      status.work_empty    = (work_len_ff == '0);
      status.work_full     = work_full;
      status.link_up       = item_link_ff;
      status.head_ok       = item_accepts_ff && cfg.kinds_enabled[work_kind_ff[0]];
      status.rsp_free      = rsp_free;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_send_valid   = res_sent_ff;
   assign rsp_send_kind    = res_kind_ff;
   assign rsp_busy_res     = res_busy_ff;
   assign rsp_queue_count  = res_qcount_ff;
   assign rsp_failed_count = res_fcount_ff;
   assign rsp_timer_armed  = res_timer_ff;
   assign rsp_pending_mask = res_mask_ff;

endmodule

`default_nettype wire

### hw/rtl/dedup_retry_send_queue.sv
// Single-outstanding send scheduler. Each request is one event (enqueue a job
// kind, send acknowledged, send nacked, time tick) and returns exactly one
// response with the send made during that event, if any, and the scheduler
// status afterwards. An accepted request is captured and decoded; an event that
// is ignored or only counts the timer down then finishes, one that reaches a
// send attempt pops each refused queue head in turn, and a retry pass first
// moves failed jobs back and then makes a send attempt. Deduplication keeps at
// most four jobs; the controller steps one queue entry per cycle through the
// shifting work queue and failed set. The finish step is held while an earlier
// response still waits unaccepted. A new request is taken once the previous
// response has been placed in the output register, even while that response
// waits. The configuration registers (retry limit, retry delay, enabled kinds)
// are written through csr_we/csr_index/csr_wdata; write them only while idle.
`default_nettype none

module dedup_retry_send_queue #(
   parameter int QUEUE_DEPTH = drsq_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   drsq_req_if.sink                               req_ch,
   drsq_rsp_if.source                             rsp_ch,
   input  wire logic                              csr_we,
   input  wire logic [drsq_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [drsq_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   drsq_pkg::cfg_type    cfg_ff, cfg_in;
   drsq_pkg::cmd_type    cmd;
   drsq_pkg::status_type status;
   logic                 req_ready;

   // Configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            drsq_pkg::CSR_RETRY_LIMIT:   cfg_in.retry_limit       = csr_wdata[2:0];
            drsq_pkg::CSR_RETRY_DELAY:   cfg_in.retry_delay_ticks = csr_wdata[15:0];
            drsq_pkg::CSR_KINDS_ENABLED: cfg_in.kinds_enabled     = csr_wdata[3:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.retry_limit       <= drsq_pkg::RETRY_LIMIT_RST;
         cfg_ff.retry_delay_ticks <= drsq_pkg::RETRY_DELAY_RST;
         cfg_ff.kinds_enabled     <= drsq_pkg::KINDS_ENABLED_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Sequencer
   drsq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   assign req_ch.ready = req_ready;

   // Queues, timer and response register
   drsq_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg_ff),
      .cmd                (cmd),
      .status             (status),
      .req_mode           (req_ch.mode),
      .req_job_kind       (req_ch.job_kind),
      .req_link_up        (req_ch.link_up),
      .req_outbox_accepts (req_ch.outbox_accepts),
      .rsp_ready          (rsp_ch.ready),
      .rsp_valid          (rsp_ch.valid),
      .rsp_send_valid     (rsp_ch.send_valid),
      .rsp_send_kind      (rsp_ch.send_kind),
      .rsp_busy_res       (rsp_ch.busy_res),
      .rsp_queue_count    (rsp_ch.queue_count),
      .rsp_failed_count   (rsp_ch.failed_count),
      .rsp_timer_armed    (rsp_ch.timer_armed),
      .rsp_pending_mask   (rsp_ch.pending_mask)
   );

endmodule

`default_nettype wire
